// ===== sv/npcs_pkg.sv =====
// ----------------------------------------------------------------------------
// npcs_pkg: nearest palette color search shared types
// transaction payloads, argb color and the token that walks the cell chain
// ----------------------------------------------------------------------------
package npcs_pkg;

  localparam int COLOR_W = 8;
  localparam int INDEX_W = 8;
  localparam int DIST_W  = 18;
  localparam int SIZE_W  = 9;

  // opcode values
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic [COLOR_W-1:0] comp_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [SIZE_W-1:0]  size_t;

  typedef struct packed {
    comp_t alpha;
    comp_t red;
    comp_t green;
    comp_t blue;
  } color_t;

  typedef struct packed {
    logic   opcode;
    index_t entry_index;
    comp_t  alpha;
    comp_t  red;
    comp_t  green;
    comp_t  blue;
  } in_item_t;

  typedef struct packed {
    index_t color_index;
    dist_t  min_distance;
  } out_item_t;

  // query in flight: color searched and best match so far
  typedef struct packed {
    color_t color;
    index_t best_idx;
    dist_t  best_dist;
  } token_t;

  // one palette write broadcast to every cell
  typedef struct packed {
    logic   en;
    index_t index;
    color_t color;
  } pal_wr_t;

endpackage

// ===== sv/npcs_cell.sv =====
// ----------------------------------------------------------------------------
// npcs_cell: one palette entry of the search chain
// holds its entry, scores a passing query against it and forwards the token
// ----------------------------------------------------------------------------
module npcs_cell import npcs_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic    clk,
  input  logic    rst_n,
  input  pal_wr_t pal_wr,
  input  size_t   search_size,
  input  logic    tok_valid_in,
  input  token_t  tok_in,
  output logic    tok_valid_out,
  output token_t  tok_out
);

  localparam index_t MY_IDX  = index_t'(INDEX);
  localparam size_t  MY_SIZE = size_t'(INDEX);
  localparam bit     FIRST   = (INDEX == 0);

  color_t entry_r;
  logic   tok_valid_r;
  token_t tok_r;
  token_t tok_nxt;

  logic [2*COLOR_W-1:0] sq_alpha, sq_red, sq_green, sq_blue;
  dist_t                score;
  logic                 active;
  logic                 take;

  function automatic logic [2*COLOR_W-1:0] sq_diff(input comp_t x, input comp_t y);
    comp_t d;
    d = (x > y) ? (x - y) : (y - x);
    return {{COLOR_W{1'b0}}, d} * {{COLOR_W{1'b0}}, d};
  endfunction

  always_comb begin
    sq_alpha = sq_diff(tok_in.color.alpha, entry_r.alpha);
    sq_red   = sq_diff(tok_in.color.red,   entry_r.red);
    sq_green = sq_diff(tok_in.color.green, entry_r.green);
    sq_blue  = sq_diff(tok_in.color.blue,  entry_r.blue);
    score    = DIST_W'(sq_alpha) + DIST_W'(sq_red) + DIST_W'(sq_green) + DIST_W'(sq_blue);
    active   = (MY_SIZE < search_size);
    // first cell always takes its score, later ones only a strictly better one
    take     = active && (FIRST || (score < tok_in.best_dist));
    tok_nxt  = tok_in;
    if (take) begin
      tok_nxt.best_idx  = MY_IDX;
      tok_nxt.best_dist = score;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_wr.en && (pal_wr.index == MY_IDX)) begin
      entry_r <= pal_wr.color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_valid_in;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign tok_valid_out = tok_valid_r;
  assign tok_out       = tok_r;

endmodule

// ===== sv/nearest_palette_color_search_top.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_search_top: nearest argb palette entry search
// a chain of palette cells scores a query by squared argb distance
// ----------------------------------------------------------------------------
// A write transaction stores one ARGB entry. A query transaction
// enters a row of PALETTE_ENTRIES cells, one cell per palette entry, and moves
// one cell per cycle; each cell within palette_size scores the query against
// its entry and keeps the lower-index best match. A query then passes the
// hold register and the output register on its way to its result
// transaction, and only one query is in the row at a time.
// The input stalls while a query is in flight; a finished result waits in the
// output register so the next transaction may be accepted meanwhile.
// palette_size 0 searches entry 0 only, values above PALETTE_ENTRIES are
// clipped, and writes to entries beyond the store are dropped. Entries read
// before being written give undefined results. Configuration writes are
// always ready and must be made only while the block is idle.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_top import npcs_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  // item input
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  // result output
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  // palette_size register
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  size_t     cfg_data
);

  localparam size_t SIZE_MAX = size_t'(PALETTE_ENTRIES);
  localparam size_t SIZE_RST = size_t'(256);

  // configuration
  size_t palette_size_r;
  size_t search_size;

  // control
  logic      busy_r, busy_nxt;
  logic      in_accept;
  logic      query_start;
  pal_wr_t   pal_wr;

  // end of chain capture and output stage
  logic      hold_valid_r, hold_valid_nxt;
  out_item_t hold_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r;
  logic      hold_move;

  // cell chain links
  logic   chain_valid [PALETTE_ENTRIES+1];
  token_t chain_tok   [PALETTE_ENTRIES+1];
  logic [PALETTE_ENTRIES-1:0] cell_valid;

  // configuration port, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_size_r <= SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      palette_size_r <= cfg_data;
    end
  end

  // effective search length: zero means one, clip to the store size
  always_comb begin
    search_size = palette_size_r;
    if (palette_size_r == '0) begin
      search_size = size_t'(1);
    end else if (palette_size_r > SIZE_MAX) begin
      search_size = SIZE_MAX;
    end
  end

  // input side: one query in flight, writes go straight to the cells
  assign in_stall    = busy_r;
  assign in_accept   = in_valid && !in_stall;
  assign query_start = in_accept && (in_data.opcode == OP_QUERY);

  assign pal_wr.en          = in_accept && (in_data.opcode == OP_WRITE);
  assign pal_wr.index       = in_data.entry_index;
  assign pal_wr.color.alpha = in_data.alpha;
  assign pal_wr.color.red   = in_data.red;
  assign pal_wr.color.green = in_data.green;
  assign pal_wr.color.blue  = in_data.blue;

  // head of the chain; best fields are overwritten by the first cell
  assign chain_valid[0]         = query_start;
  assign chain_tok[0].color     = pal_wr.color;
  assign chain_tok[0].best_idx  = '0;
  assign chain_tok[0].best_dist = '0;

  for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
    npcs_cell #(
      .INDEX(i)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .pal_wr       (pal_wr),
      .search_size  (search_size),
      .tok_valid_in (chain_valid[i]),
      .tok_in       (chain_tok[i]),
      .tok_valid_out(chain_valid[i+1]),
      .tok_out      (chain_tok[i+1])
    );
    assign cell_valid[i] = chain_valid[i+1];
  end

  // hold register catches the chain output, moves on when the output frees
  assign hold_move = hold_valid_r && (!out_valid_r || !out_stall);

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    out_valid_nxt  = out_valid_r;
    busy_nxt       = busy_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (hold_move) begin
      hold_valid_nxt = 1'b0;
      out_valid_nxt  = 1'b1;
      busy_nxt       = 1'b0;
    end
    if (chain_valid[PALETTE_ENTRIES]) begin
      hold_valid_nxt = 1'b1;
    end
    if (query_start) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (chain_valid[PALETTE_ENTRIES]) begin
      hold_r.color_index  <= chain_tok[PALETTE_ENTRIES].best_idx;
      hold_r.min_distance <= chain_tok[PALETTE_ENTRIES].best_dist;
    end
    if (hold_move) begin
      out_r <= hold_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // at most one query token anywhere in the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) <= 1)
    else $error("more than one query in the cell chain");

  // a query in the chain or in the hold register keeps the input stalled
  a_busy_cover: assert property (@(posedge clk) disable iff (!rst_n)
    ((|cell_valid) || hold_valid_r) |-> busy_r)
    else $error("query in flight while input is open");

  // the chain never delivers into an occupied hold register
  a_hold_free: assert property (@(posedge clk) disable iff (!rst_n)
    chain_valid[PALETTE_ENTRIES] |-> !hold_valid_r)
    else $error("chain result overruns hold register");

  // a result never exceeds the largest possible argb distance
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.min_distance <= dist_t'(260100)))
    else $error("result distance out of range");

endmodule

// ===== tb/nearest_palette_color_search_top_tb.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_search_top_tb: self-checking bench for the palette search
// random palette writes and nearest-color queries go through a queue-fed driver.
// A shadow palette scores every accepted query to build the expected results.
// The monitor checks each result transaction against them, field by field.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_top_tb;
  import npcs_pkg::*;

  localparam int          CLK_PERIOD     = 4;
  localparam int          PAL_DEPTH      = 256;
  localparam int          SETTLE_CYCLES  = PAL_DEPTH + 8;   // cell chain length plus margin
  localparam int          TIMEOUT_CYCLES = 1_000_000;
  localparam int          HOLD_CYCLES    = 600;
  localparam int          IDLE_PCT       = 38;
  localparam int          MAX_REPORTS    = 10;
  localparam int unsigned DIST_START     = 32'hffffff;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  size_t     cfg_data  = '0;

  // bench state shared by driver, receiver and monitor
  logic        in_acc        = 1'b0;   // input transaction taken at the last rising edge
  bit          steady        = 1'b0;   // no idling on either side while set
  bit          hold_req      = 1'b0;   // asks the receiver for one long hold-off
  logic        hold_results  = 1'b0;
  int unsigned cfg_count     = 0;
  int unsigned mismatch_count = 0;

  in_item_t  queued_items[$];       // items not yet offered to the block
  out_item_t pending_matches[$];    // nearest matches still owed by the block

  // shadow of the block: palette contents and search size as seen at the handshakes
  color_t shadow_palette[PAL_DEPTH];
  size_t  search_size;

  // generator view of the palette, used to keep queries off unwritten entries
  color_t      gen_pal[PAL_DEPTH];
  bit          gen_written[PAL_DEPTH];
  int unsigned gen_span;

  nearest_palette_color_search_top #(
    .PALETTE_ENTRIES(PAL_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // nearest match prediction
  // ---------------------------------------------------------------------------
  function automatic int unsigned sq_diff(comp_t a, comp_t b);
    int unsigned d;
    d = (a > b) ? (a - b) : (b - a);
    return d * d;
  endfunction

  // scan the searched entries; strict less-than keeps the lowest index on a tie
  function automatic out_item_t nearest_entry(color_t c);
    int unsigned span;
    int unsigned d;
    int unsigned best_d;
    index_t      best_i;
    out_item_t   r;
    // size zero still searches entry 0, oversize clips to the store depth
    span = (search_size == 0) ? 1 : search_size;
    if (span > PAL_DEPTH) span = PAL_DEPTH;
    best_d = DIST_START;
    best_i = '0;
    for (int k = 0; k < span; k++) begin
      d = sq_diff(c.alpha, shadow_palette[k].alpha) + sq_diff(c.red, shadow_palette[k].red)
        + sq_diff(c.green, shadow_palette[k].green) + sq_diff(c.blue, shadow_palette[k].blue);
      if (d < best_d) begin
        best_d = d;
        best_i = index_t'(k);
      end
    end
    r.color_index  = best_i;
    r.min_distance = dist_t'(best_d);
    return r;
  endfunction

  task automatic flag_error(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // monitor: everything is sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_acc <= rst_n && in_valid && !in_stall;
    if (!rst_n) begin
      search_size = size_t'(PAL_DEPTH);
    end else begin
      if (cfg_valid && cfg_ready) begin
        search_size = cfg_data;
        cfg_count++;
      end
      // input transaction: a write updates the shadow, a query owes one result
      if (in_valid && !in_stall) begin
        if (in_data.opcode == OP_WRITE) begin
          if (in_data.entry_index < PAL_DEPTH)
            shadow_palette[in_data.entry_index] =
              {in_data.alpha, in_data.red, in_data.green, in_data.blue};
        end else begin
          pending_matches.push_back(
            nearest_entry({in_data.alpha, in_data.red, in_data.green, in_data.blue}));
        end
      end
      // result transaction against the oldest expectation
      if (out_valid && !out_stall) begin
        if (pending_matches.size() == 0) begin
          flag_error($sformatf("unexpected result: index %0d distance %0d",
                               out_data.color_index, out_data.min_distance));
        end else begin
          out_item_t exp_m;
          exp_m = pending_matches.pop_front();
          if (out_data.color_index !== exp_m.color_index)
            flag_error($sformatf("color_index mismatch: expected %0d, got %0d",
                                 exp_m.color_index, out_data.color_index));
          if (out_data.min_distance !== exp_m.min_distance)
            flag_error($sformatf("min_distance mismatch: expected %0d, got %0d",
                                 exp_m.min_distance, out_data.min_distance));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driver: holds a stalled item, otherwise offers the next one or idles
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (queued_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_data  <= queued_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall, none while steady, solid during the hold-off
  always @(negedge clk) begin
    out_stall <= hold_results || (!steady && $urandom_range(99) < IDLE_PCT);
  end

  // long hold-off on the result side, counted here while the sender keeps going
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_results <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_results <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic wait_drained();
    do @(posedge clk);
    while (queued_items.size() != 0 || in_valid || pending_matches.size() != 0);
  endtask

  // register write only when idle: drain, then let a possible trailing write settle
  task automatic set_search_size(size_t v);
    int unsigned seen;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    gen_span = (v == 0) ? 1 : ((v > PAL_DEPTH) ? PAL_DEPTH : v);
    seen = cfg_count;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(negedge clk);
    while (cfg_count == seen);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_write(index_t idx, color_t c);
    in_item_t it;
    it.opcode      = OP_WRITE;
    it.entry_index = idx;
    {it.alpha, it.red, it.green, it.blue} = c;
    queued_items.push_back(it);
    gen_pal[idx]     = c;
    gen_written[idx] = 1'b1;
  endtask

  task automatic queue_query(color_t c);
    in_item_t it;
    it.opcode      = OP_QUERY;
    it.entry_index = index_t'($urandom);   // ignored by the block
    {it.alpha, it.red, it.green, it.blue} = c;
    queued_items.push_back(it);
  endtask

  // copies and near copies of entries make exact hits and ties common
  function automatic color_t pick_color();
    color_t      c;
    int unsigned k;
    k = $urandom_range(gen_span - 1);
    c = color_t'($urandom);
    case ($urandom_range(3))
      0: c = gen_pal[k];
      1: c = {{8{c.alpha[0]}}, {8{c.red[0]}}, {8{c.green[0]}}, {8{c.blue[0]}}};
      2: begin
        c = gen_pal[k];
        c.green = c.green ^ comp_t'($urandom_range(3));
      end
      default: ;
    endcase
    return c;
  endfunction

  // every searched entry gets written before any query can read it
  task automatic random_traffic(int n);
    index_t idx;
    for (int k = 0; k < gen_span; k++)
      if (!gen_written[k]) queue_write(index_t'(k), color_t'($urandom));
    repeat (n) begin
      if ($urandom_range(99) < 40) begin
        idx = ($urandom_range(3) == 0) ? index_t'($urandom_range(PAL_DEPTH - 1))
                                       : index_t'($urandom_range(gen_span - 1));
        queue_write(idx, pick_color());
      end else begin
        queue_query(pick_color());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < PAL_DEPTH; k++) gen_written[k] = 1'b0;
    gen_span = PAL_DEPTH;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // size zero searches entry 0 only, even with an exact match at entry 1
    set_search_size(size_t'(0));
    queue_write(8'd0, 32'h0000_0000);
    queue_query(32'hffff_ffff);                 // largest possible distance
    queue_query(32'h0000_0000);                 // exact match
    queue_write(8'd1, 32'hffff_ffff);
    queue_write(8'd2, 32'h8080_8080);
    queue_write(8'd3, 32'h8080_8080);
    queue_write(8'd255, 32'h1234_5678);         // top entry of the store
    queue_query(32'hffff_ffff);

    // two entries at equal distance: lowest index wins
    set_search_size(size_t'(2));
    queue_query(32'hffff_0000);
    queue_query(32'h00ff_ff00);

    // duplicate entries 2 and 3, exact hits and near misses
    set_search_size(size_t'(4));
    queue_query(32'h8080_8080);
    queue_query(32'hffff_ffff);
    queue_query(32'h7f80_8180);
    queue_query(32'h0101_0101);
    queue_query(32'hc0c0_c0c0);

    set_search_size(size_t'(1));
    queue_query(32'h8080_8080);
    queue_query(32'h00ff_00ff);

    // no idling at all on either side
    set_search_size(size_t'(16));
    steady = 1'b1;
    random_traffic(50);
    wait_drained();
    steady = 1'b0;

    // full search, fills the whole store first
    set_search_size(size_t'(PAL_DEPTH));
    random_traffic(70);

    // oversize clips to the full store; results held off so the input backs up,
    // then the sender pauses until every result is back
    set_search_size(size_t'(511));
    hold_req = 1'b1;
    random_traffic(30);
    wait_drained();
    random_traffic(30);

    set_search_size(size_t'(300));
    random_traffic(40);
    set_search_size(size_t'(2));
    random_traffic(40);
    set_search_size(size_t'(1));
    random_traffic(30);
    set_search_size(size_t'(128));
    random_traffic(40);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_matches.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog on the whole run
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("FAILURE");
    $finish;
  end

endmodule
